### design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high
`define BDM_ASSERT(name, ck, rs, prop) \
  name: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("bdm assertion failed");

// Clocked assertion that also holds during reset
`define BDM_ASSERT_NR(name, ck, prop) \
  name: assert property (@(posedge ck) prop) \
    else $error("bdm assertion failed");

`endif

### design/bdm_pkg.sv
// Shared types, constants and functions of the Bayer demosaic block
package bdm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int STORED_LINES  = 4;
  localparam int BANK_W        = 2;
  localparam int CFG_W_BITS    = 11;
  localparam int ROW_W         = 16;
  localparam int MIN_DIM       = 4;
  localparam int WIDTH_RESET   = 390;
  localparam int HEIGHT_RESET  = 300;
  localparam int NUM_TAPS      = 13;
  localparam int NUM_COLS      = 5;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [7:0] pix_t;
  typedef pix_t [STORED_LINES-1:0] col_t;
  typedef pix_t [NUM_TAPS-1:0] taps_t;

  // Per-item context that travels with the window fetch
  typedef struct packed {
    logic              produce;
    logic              last;
    logic              r_odd;
    logic              c_odd;
    logic              col_first;
    logic              col_second;
    logic              col_pen;
    logic              col_last;
    logic              live_m2;
    logic              live_p2;
    logic [BANK_W-1:0] bank_c0;
    logic [BANK_W-1:0] bank_m2;
    logic [BANK_W-1:0] bank_m1;
    logic [BANK_W-1:0] bank_p1;
    logic [BANK_W-1:0] bank_p2;
    pix_t              sample;
  } ctx_t;

  // Divide by 16 toward zero, clamp to 0..255
  function automatic pix_t finish(input logic signed [15:0] s);
    pix_t q;
    if (s < 0) begin
      q = 8'd0;
    end else if (s[15:12] != 4'd0) begin
      q = 8'd255;
    end else begin
      q = s[11:4];
    end
    return q;
  endfunction

endpackage

### design/bdm_in_if.sv
// Input channel: raw samples and flush ticks
interface bdm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] raw_sample;
  modport source (output valid, cmd, raw_sample, input ready);
  modport sink (input valid, cmd, raw_sample, output ready);
endinterface

### design/bdm_out_if.sv
// Output channel: RGB pixels
interface bdm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_last;
  modport source (output valid, red, green, blue, frame_last, input ready);
  modport sink (input valid, red, green, blue, frame_last, output ready);
endinterface

### design/bdm_ram.sv
// Generic single-write, single-read RAM with registered read data
module bdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/bdm_ctrl.sv
// Raster counters, line store addressing and per-item context
module bdm_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         accept,
  input  logic                         restart,
  input  logic                         cmd,
  input  logic [7:0]                   sample,
  input  logic [$clog2(MAX_WIDTH):0]   eff_w,
  input  logic [15:0]                  eff_h,
  output logic                         rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic                         wr_en,
  output logic [1:0]                   wr_bank,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output logic                         v_b,
  output bdm_pkg::ctx_t                ctx_b
);
  import bdm_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [ROW_W-1:0] in_row, out_row, out_row_adv, r_m1, r_m2, r_p1, h_m1;
  logic [COL_W-1:0] in_col, out_col, out_col_adv, c, w_m1, w_m2;
  logic             is_raw, act, flush_lastrow;
  ctx_t             ctx;

  always_comb begin
    w_m1   = COL_W'(eff_w - 1'b1);
    w_m2   = COL_W'(eff_w - 2'd2);
    h_m1   = eff_h - 16'd1;
    is_raw = (cmd == CMD_SAMPLE);
    act    = is_raw ? (in_row < eff_h) : ((in_row >= eff_h) && (out_row < eff_h));
    c      = is_raw ? in_col : out_col;
    r_m1   = out_row - 16'd1;
    r_m2   = out_row - 16'd2;
    r_p1   = out_row + 16'd1;
    flush_lastrow = (out_row == h_m1);

    if (out_col == w_m1) begin
      out_col_adv = '0;
      out_row_adv = out_row + 16'd1;
    end else begin
      out_col_adv = out_col + 1'b1;
      out_row_adv = out_row;
    end

    ctx.produce    = is_raw ? (in_row >= 16'd2) : 1'b1;
    ctx.last       = !is_raw && flush_lastrow && (out_col == w_m1);
    ctx.r_odd      = out_row[0];
    ctx.c_odd      = c[0];
    ctx.col_first  = (c == '0);
    ctx.col_second = (c == COL_W'(1));
    ctx.col_pen    = (c == w_m2);
    ctx.col_last   = (c == w_m1);
    ctx.live_m2    = is_raw && (out_row == '0);
    ctx.live_p2    = is_raw;
    ctx.bank_c0    = out_row[1:0];
    ctx.bank_m2    = (out_row == 16'd1) ? 2'd1 : r_m2[1:0];
    ctx.bank_m1    = (out_row == '0) ? 2'd1 : r_m1[1:0];
    ctx.bank_p1    = (!is_raw && flush_lastrow) ? r_m1[1:0] : r_p1[1:0];
    ctx.bank_p2    = flush_lastrow ? r_m2[1:0] : out_row[1:0];
    ctx.sample     = sample;

    // Read two columns ahead; the last two columns prefetch the next row's start
    rd_en = accept && act;
    if (c < w_m2) begin
      rd_addr = c + COL_W'(2);
    end else if (c == w_m2) begin
      rd_addr = '0;
    end else begin
      rd_addr = COL_W'(1);
    end

    wr_en   = accept && act && is_raw;
    wr_bank = in_row[1:0];
    wr_addr = in_col;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (accept && act) begin
      if (is_raw) begin
        if (ctx.produce) begin
          out_row <= out_row_adv;
          out_col <= out_col_adv;
        end
        if (in_col == w_m1) begin
          in_col <= '0;
          in_row <= in_row + 16'd1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end else if (ctx.last) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        out_row <= out_row_adv;
        out_col <= out_col_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en) begin
      v_b <= accept && act;
    end
    if (en) begin
      ctx_b <= ctx;
    end
  end

endmodule

### design/bdm_window.sv
// Five-column window over the four line banks, with edge mirroring
module bdm_window (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          v_b,
  input  bdm_pkg::ctx_t ctx_b,
  input  bdm_pkg::col_t rd_col,
  output logic          v_d,
  output bdm_pkg::ctx_t ctx_d,
  output bdm_pkg::taps_t taps_d
);
  import bdm_pkg::*;

  col_t  sr [NUM_COLS];
  ctx_t  ctx_c;
  logic  v_c;
  taps_t taps;
  logic [2:0] i_m2, i_m1, i_p1, i_p2;

  // sr[0] holds column c+2, sr[4] column c-2
  always_comb begin
    i_m2 = ctx_c.col_first ? 3'd0 : (ctx_c.col_second ? 3'd2 : 3'd4);
    i_m1 = ctx_c.col_first ? 3'd1 : 3'd3;
    i_p1 = ctx_c.col_last ? 3'd3 : 3'd1;
    i_p2 = ctx_c.col_last ? 3'd4 : (ctx_c.col_pen ? 3'd2 : 3'd0);

    taps[0]  = sr[2][ctx_c.bank_c0];
    taps[1]  = sr[2][ctx_c.bank_m1];
    taps[2]  = sr[2][ctx_c.bank_p1];
    taps[3]  = sr[i_m1][ctx_c.bank_c0];
    taps[4]  = sr[i_p1][ctx_c.bank_c0];
    taps[5]  = ctx_c.live_m2 ? ctx_c.sample : sr[2][ctx_c.bank_m2];
    taps[6]  = ctx_c.live_p2 ? ctx_c.sample : sr[2][ctx_c.bank_p2];
    taps[7]  = sr[i_m2][ctx_c.bank_c0];
    taps[8]  = sr[i_p2][ctx_c.bank_c0];
    taps[9]  = sr[i_m1][ctx_c.bank_m1];
    taps[10] = sr[i_p1][ctx_c.bank_m1];
    taps[11] = sr[i_m1][ctx_c.bank_p1];
    taps[12] = sr[i_p1][ctx_c.bank_p1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else if (en) begin
      v_c <= v_b;
      v_d <= v_c && ctx_c.produce;
    end
    if (en) begin
      if (v_b) begin
        for (int i = NUM_COLS - 1; i > 0; i--) begin
          sr[i] <= sr[i-1];
        end
        sr[0] <= rd_col;
      end
      ctx_c  <= ctx_b;
      ctx_d  <= ctx_c;
      taps_d <= taps;
    end
  end

endmodule

### design/bdm_kernel.sv
// MHC filter sums, scaling, channel select and output register
module bdm_kernel (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           v_d,
  input  bdm_pkg::ctx_t  ctx_d,
  input  bdm_pkg::taps_t taps_d,
  output logic           out_valid,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue,
  output logic           frame_last
);
  import bdm_pkg::*;

  logic signed [15:0] c0, n, s, w, e, nn, ss, ww, ee, d;
  logic signed [15:0] cr, hz, vt, dg;
  pix_t r_n, g_n, b_n;

  always_comb begin
    c0 = 16'(taps_d[0]);
    n  = 16'(taps_d[1]);
    s  = 16'(taps_d[2]);
    w  = 16'(taps_d[3]);
    e  = 16'(taps_d[4]);
    nn = 16'(taps_d[5]);
    ss = 16'(taps_d[6]);
    ww = 16'(taps_d[7]);
    ee = 16'(taps_d[8]);
    d  = 16'(taps_d[9]) + 16'(taps_d[10]) + 16'(taps_d[11]) + 16'(taps_d[12]);

    cr = 16'sd8 * c0 + 16'sd4 * (n + s + w + e) - 16'sd2 * (nn + ss + ww + ee);
    hz = 16'sd10 * c0 + 16'sd8 * (w + e) - 16'sd2 * (ww + ee) - 16'sd2 * d + (nn + ss);
    vt = 16'sd10 * c0 + 16'sd8 * (n + s) - 16'sd2 * (nn + ss) - 16'sd2 * d + (ww + ee);
    dg = 16'sd12 * c0 + 16'sd4 * d - 16'sd3 * (nn + ss + ww + ee);

    unique case ({ctx_d.r_odd, ctx_d.c_odd})
      2'b00: begin
        r_n = finish(hz); g_n = taps_d[0]; b_n = finish(vt);
      end
      2'b01: begin
        r_n = taps_d[0]; g_n = finish(cr); b_n = finish(dg);
      end
      2'b10: begin
        r_n = finish(dg); g_n = finish(cr); b_n = taps_d[0];
      end
      default: begin
        r_n = finish(vt); g_n = taps_d[0]; b_n = finish(hz);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_d;
    end
    if (en) begin
      red        <= r_n;
      green      <= g_n;
      blue       <= b_n;
      frame_last <= ctx_d.last;
    end
  end

endmodule

### design/bayer_demosaic_mhc.sv
// Bayer demosaic (Malvar-He-Cutler 5x5) top level
//
// in_ch takes one request per cycle: cmd selects a raw Bayer sample or a
// flush tick. Samples come in raster order, green at even/even sites.
// out_ch carries one RGB pixel per producing request, with frame_last on
// the final pixel. Rows 0 and 1 give no pixel; pixel (r,c) leaves with
// sample (r+2,c), and after the frame two rows of flush ticks drain it.
// Samples past the frame end and early flush ticks are dropped.
// Throughput: one request per cycle unless out_ch stalls. Each sample
// in the frame makes one read of the four line banks (one column, two
// ahead) and one write; a draining flush tick only reads. A stalled
// out_ch holds the output register and the whole pipeline, and
// in_ch.ready drops until the pixel is taken. Reset clears the counters
// and the pipeline; the line store needs no clearing, since every entry
// is written before it is read. APB writes (width at 0x0, height at 0x4)
// restart the frame.
module bayer_demosaic_mhc #(
  parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bdm_in_if.sink      in_ch,
  bdm_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bdm_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [CFG_W_BITS-1:0] image_width;
  logic [ROW_W-1:0]      image_height, eff_h;
  logic [COL_W:0]        eff_w;
  reg_idx_t              reg_idx;
  logic                  cfg_wr, en, accept, out_valid;
  logic                  rd_en, wr_en, v_b, v_d;
  logic [1:0]            wr_bank;
  logic [COL_W-1:0]      rd_addr, wr_addr;
  ctx_t                  ctx_b, ctx_d;
  col_t                  rd_col;
  taps_t                 taps_d;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W_BITS'(WIDTH_RESET);
      image_height <= ROW_W'(HEIGHT_RESET);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_width) > MAX_WIDTH) begin
      eff_w = (COL_W+1)'(MAX_WIDTH);
    end else if (32'(image_width) < MIN_DIM) begin
      eff_w = (COL_W+1)'(MIN_DIM);
    end else begin
      eff_w = (COL_W+1)'(image_width);
    end
    eff_h = (32'(image_height) < MIN_DIM) ? ROW_W'(MIN_DIM) : image_height;
  end

  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en;
  assign accept      = in_ch.valid && en;

  bdm_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .accept  (accept),
    .restart (cfg_wr),
    .cmd     (in_ch.cmd),
    .sample  (in_ch.raw_sample),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_bank (wr_bank),
    .wr_addr (wr_addr),
    .v_b     (v_b),
    .ctx_b   (ctx_b)
  );

  // One bank per stored row; row n lives in bank n mod 4
  for (genvar g = 0; g < STORED_LINES; g++) begin : g_bank
    bdm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (wr_en && (wr_bank == 2'(g))),
      .waddr (wr_addr),
      .wdata (in_ch.raw_sample),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rd_col[g])
    );
  end

  bdm_window u_window (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .v_b    (v_b),
    .ctx_b  (ctx_b),
    .rd_col (rd_col),
    .v_d    (v_d),
    .ctx_d  (ctx_d),
    .taps_d (taps_d)
  );

  bdm_kernel u_kernel (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .v_d        (v_d),
    .ctx_d      (ctx_d),
    .taps_d     (taps_d),
    .out_valid  (out_valid),
    .red        (out_ch.red),
    .green      (out_ch.green),
    .blue       (out_ch.blue),
    .frame_last (out_ch.frame_last)
  );

  assign out_ch.valid = out_valid;

endmodule

### design/bdm_checker.sv
// Port-level checks of the demosaic block, bound to the top level
`include "assert_macros.svh"

module bdm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [24:0] out_data
);

  `BDM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `BDM_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_data))
  `BDM_ASSERT(a_stall_blocks_in, clk, rst, out_valid && !out_ready |-> !in_ready)
  `BDM_ASSERT_NR(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind bayer_demosaic_mhc bdm_checker u_bdm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.red, out_ch.green, out_ch.blue, out_ch.frame_last})
);
